>>> sv/sci_pkg.sv
package sci_pkg;

  localparam int FIELD_W        = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int NUM_STAGES     = 6;

  typedef struct packed {
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
    logic signed [FIELD_W-1:0] centre_x;
    logic signed [FIELD_W-1:0] centre_y;
    logic signed [FIELD_W-1:0] radius;
  } in_t;

  typedef struct packed {
    logic intersects;
    logic bad_radius;
  } out_t;

endpackage

>>> sv/sci_diff_stage.sv
module sci_diff_stage import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  in_t                  item,
  output logic signed [DW-1:0] dx_r,
  output logic signed [DW-1:0] dy_r,
  output logic signed [DW-1:0] fx_r,
  output logic signed [DW-1:0] fy_r,
  output logic signed [DW-1:0] gx_r,
  output logic signed [DW-1:0] gy_r,
  output logic signed [DW-1:0] r_r,
  output logic                 bad_r
);

  logic signed [COORD_BITS-1:0] sx, sy, ex, ey, cx, cy, rr;

  assign sx = COORD_BITS'($signed(item.start_x));
  assign sy = COORD_BITS'($signed(item.start_y));
  assign ex = COORD_BITS'($signed(item.end_x));
  assign ey = COORD_BITS'($signed(item.end_y));
  assign cx = COORD_BITS'($signed(item.centre_x));
  assign cy = COORD_BITS'($signed(item.centre_y));
  assign rr = COORD_BITS'($signed(item.radius));

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DW'(ex) - DW'(sx);
      dy_r  <= DW'(ey) - DW'(sy);
      fx_r  <= DW'(sx) - DW'(cx);
      fy_r  <= DW'(sy) - DW'(cy);
      gx_r  <= DW'(ex) - DW'(cx);
      gy_r  <= DW'(ey) - DW'(cy);
      r_r   <= DW'(rr);
      bad_r <= rr[COORD_BITS-1] || (rr == '0);
    end
  end

endmodule

>>> sv/sci_prod_stage.sv
module sci_prod_stage import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] dx,
  input  logic signed [DW-1:0] dy,
  input  logic signed [DW-1:0] fx,
  input  logic signed [DW-1:0] fy,
  input  logic signed [DW-1:0] gx,
  input  logic signed [DW-1:0] gy,
  input  logic signed [DW-1:0] r,
  input  logic                 bad,
  output logic signed [PW-1:0] dxdx_r,
  output logic signed [PW-1:0] dydy_r,
  output logic signed [PW-1:0] fxfx_r,
  output logic signed [PW-1:0] fyfy_r,
  output logic signed [PW-1:0] gxgx_r,
  output logic signed [PW-1:0] gygy_r,
  output logic signed [PW-1:0] rr_r,
  output logic signed [PW-1:0] fxdx_r,
  output logic signed [PW-1:0] fydy_r,
  output logic signed [PW-1:0] fxdy_r,
  output logic signed [PW-1:0] fydx_r,
  output logic                 bad_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      dxdx_r <= dx * dx;
      dydy_r <= dy * dy;
      fxfx_r <= fx * fx;
      fyfy_r <= fy * fy;
      gxgx_r <= gx * gx;
      gygy_r <= gy * gy;
      rr_r   <= r * r;
      fxdx_r <= fx * dx;
      fydy_r <= fy * dy;
      fxdy_r <= fx * dy;
      fydx_r <= fy * dx;
      bad_r  <= bad;
    end
  end

endmodule

>>> sv/sci_sum_stage.sv
module sci_sum_stage import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW,
  localparam int SW = PW + 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [PW-1:0] dxdx,
  input  logic signed [PW-1:0] dydy,
  input  logic signed [PW-1:0] fxfx,
  input  logic signed [PW-1:0] fyfy,
  input  logic signed [PW-1:0] gxgx,
  input  logic signed [PW-1:0] gygy,
  input  logic signed [PW-1:0] rr,
  input  logic signed [PW-1:0] fxdx,
  input  logic signed [PW-1:0] fydy,
  input  logic signed [PW-1:0] fxdy,
  input  logic signed [PW-1:0] fydx,
  input  logic                 bad,
  output logic        [PW-1:0] a_r,
  output logic        [PW-1:0] ff_r,
  output logic        [PW-1:0] gg_r,
  output logic        [PW-1:0] r2_r,
  output logic        [PW-1:0] cm_r,
  output logic signed [SW-1:0] dot_r,
  output logic                 bad_r
);

  logic signed [SW-1:0] c_pos, c_neg;

  assign c_pos = SW'(fxdy) - SW'(fydx);
  assign c_neg = SW'(fydx) - SW'(fxdy);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= $unsigned(dxdx) + $unsigned(dydy);
      ff_r  <= $unsigned(fxfx) + $unsigned(fyfy);
      gg_r  <= $unsigned(gxgx) + $unsigned(gygy);
      r2_r  <= $unsigned(rr);
      dot_r <= SW'(fxdx) + SW'(fydy);
      cm_r  <= c_pos[SW-1] ? c_neg[PW-1:0] : c_pos[PW-1:0];
      bad_r <= bad;
    end
  end

endmodule

>>> sv/sci_cmp_stage.sv
module sci_cmp_stage import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW,
  localparam int SW = PW + 1,
  localparam int HW = DW,
  localparam int LW = 4 * HW
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic        [PW-1:0] a,
  input  logic        [PW-1:0] ff,
  input  logic        [PW-1:0] gg,
  input  logic        [PW-1:0] r2,
  input  logic        [PW-1:0] cm,
  input  logic signed [SW-1:0] dot,
  input  logic                 bad,
  output out_t                 res_r
);

  logic signed [SW-1:0] a_plus_dot;
  logic [HW-1:0]        cm_lo, cm_hi, r2_lo, r2_hi, a_lo, a_hi;

  logic [2*HW-1:0] cll_r, clh_r, chh_r;
  logic [2*HW-1:0] rll_r, rlh_r, rhl_r, rhh_r;
  logic            inside_r, seg_r, bad4_r;

  logic [LW-1:0]   lhs_r, rhs_r;
  logic            inside5_r, seg5_r, bad5_r;

  out_t            res_nxt;

  assign a_plus_dot = $signed({1'b0, a}) + dot;
  assign cm_lo = cm[HW-1:0];
  assign cm_hi = cm[PW-1:HW];
  assign r2_lo = r2[HW-1:0];
  assign r2_hi = r2[PW-1:HW];
  assign a_lo  = a[HW-1:0];
  assign a_hi  = a[PW-1:HW];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cll_r    <= cm_lo * cm_lo;
      clh_r    <= cm_lo * cm_hi;
      chh_r    <= cm_hi * cm_hi;
      rll_r    <= r2_lo * a_lo;
      rlh_r    <= r2_lo * a_hi;
      rhl_r    <= r2_hi * a_lo;
      rhh_r    <= r2_hi * a_hi;
      inside_r <= (ff <= r2) || (gg <= r2);
      seg_r    <= (a != '0) && dot[SW-1] && !a_plus_dot[SW-1];
      bad4_r   <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lhs_r     <= (LW'(chh_r) << (2 * HW)) + (LW'(clh_r) << (HW + 1)) + LW'(cll_r);
      rhs_r     <= (LW'(rhh_r) << (2 * HW)) + ((LW'(rlh_r) + LW'(rhl_r)) << HW)
                   + LW'(rll_r);
      inside5_r <= inside_r;
      seg5_r    <= seg_r;
      bad5_r    <= bad4_r;
    end
  end

  always_comb begin
    res_nxt.bad_radius = bad5_r;
    res_nxt.intersects = !bad5_r && (inside5_r || (seg5_r && (lhs_r <= rhs_r)));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> sv/segment_circle_intersect_unit.sv
// Segment / circle intersection test, six register stages.
// An accepted item passes the diff, prod, sum and cmp stages in order.
// Throughput: one item per cycle when out_stall is low; bubbles
// collapse, so a stalled result holds only occupied stages behind it.
// Reset: synchronous, active low; clears all stage valid bits.
module segment_circle_intersect_unit import sci_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic [NUM_STAGES-1:0] v_r, v_nxt, rdy;

  logic signed [DW-1:0] dx, dy, fx, fy, gx, gy, r;
  logic                 bad1, bad2, bad3;

  logic signed [PW-1:0] dxdx, dydy, fxfx, fyfy, gxgx, gygy, rr, fxdx, fydy, fxdy, fydx;

  logic        [PW-1:0] a, ff, gg, r2, cm;
  logic signed [SW-1:0] dot;

  always_comb begin
    rdy[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NUM_STAGES-1];

  sci_diff_stage #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk   (clk),
    .en    (rdy[0]),
    .item  (in_data),
    .dx_r  (dx),
    .dy_r  (dy),
    .fx_r  (fx),
    .fy_r  (fy),
    .gx_r  (gx),
    .gy_r  (gy),
    .r_r   (r),
    .bad_r (bad1)
  );

  sci_prod_stage #(.COORD_BITS(COORD_BITS)) u_prod (
    .clk    (clk),
    .en     (rdy[1]),
    .dx     (dx),
    .dy     (dy),
    .fx     (fx),
    .fy     (fy),
    .gx     (gx),
    .gy     (gy),
    .r      (r),
    .bad    (bad1),
    .dxdx_r (dxdx),
    .dydy_r (dydy),
    .fxfx_r (fxfx),
    .fyfy_r (fyfy),
    .gxgx_r (gxgx),
    .gygy_r (gygy),
    .rr_r   (rr),
    .fxdx_r (fxdx),
    .fydy_r (fydy),
    .fxdy_r (fxdy),
    .fydx_r (fydx),
    .bad_r  (bad2)
  );

  sci_sum_stage #(.COORD_BITS(COORD_BITS)) u_sum (
    .clk   (clk),
    .en    (rdy[2]),
    .dxdx  (dxdx),
    .dydy  (dydy),
    .fxfx  (fxfx),
    .fyfy  (fyfy),
    .gxgx  (gxgx),
    .gygy  (gygy),
    .rr    (rr),
    .fxdx  (fxdx),
    .fydy  (fydy),
    .fxdy  (fxdy),
    .fydx  (fydx),
    .bad   (bad2),
    .a_r   (a),
    .ff_r  (ff),
    .gg_r  (gg),
    .r2_r  (r2),
    .cm_r  (cm),
    .dot_r (dot),
    .bad_r (bad3)
  );

  sci_cmp_stage #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk   (clk),
    .en    (rdy[5:3]),
    .a     (a),
    .ff    (ff),
    .gg    (gg),
    .r2    (r2),
    .cm    (cm),
    .dot   (dot),
    .bad   (bad3),
    .res_r (out_data)
  );

  a_no_hit_on_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.intersects && out_data.bad_radius))
    else $error("intersects set together with bad_radius");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted item not captured in first stage");

  a_empty_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> !in_stall)
    else $error("input stalled with empty first stage");

  a_drain_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !v_r[NUM_STAGES-2]) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

>>> bench/tb_top.sv
module tb_top;
  import sci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1830;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 2 * NUM_STAGES + 10;

  localparam out_t HIT   = '{intersects: 1'b1, bad_radius: 1'b0};
  localparam out_t MISS  = '{intersects: 1'b0, bad_radius: 1'b0};
  localparam out_t BAD_R = '{intersects: 1'b0, bad_radius: 1'b1};

  typedef struct {
    in_t  query;
    bit   typed;
    out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic drv_typed = 1'b0;
  out_t drv_want = '0;

  out_t verdict_q[$];
  int   errors = 0;
  int   quiet = 0;
  int   burst_left = 0;

  segment_circle_intersect_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic out_t segment_hits_disc(in_t q);
    longint sx, sy, ex, ey, cx, cy, r;
    longint dx, dy, fx, fy, gx, gy, len2, ff, gg, r2, dot, xprod;
    bit [127:0] lhs, rhs, len_w;
    bit [63:0] cmag;
    out_t res;
    res = MISS;
    sx = longint'(q.start_x);
    sy = longint'(q.start_y);
    ex = longint'(q.end_x);
    ey = longint'(q.end_y);
    cx = longint'(q.centre_x);
    cy = longint'(q.centre_y);
    r  = longint'(q.radius);
    if (r <= 0) return BAD_R;
    dx = ex - sx;
    dy = ey - sy;
    fx = sx - cx;
    fy = sy - cy;
    gx = ex - cx;
    gy = ey - cy;
    len2 = dx * dx + dy * dy;
    ff = fx * fx + fy * fy;
    gg = gx * gx + gy * gy;
    r2 = r * r;
    if (ff <= r2 || gg <= r2) begin
      res.intersects = 1'b1;
    end else if (len2 != 0) begin
      dot = fx * dx + fy * dy;
      if (dot < 0 && -dot <= len2) begin
        xprod = fx * dy - fy * dx;
        cmag = (xprod < 0) ? 64'(-xprod) : 64'(xprod);
        lhs = 128'(cmag);
        lhs = lhs * lhs;
        rhs = 128'(64'(r2));
        len_w = 128'(64'(len2));
        rhs = rhs * len_w;
        res.intersects = (lhs <= rhs);
      end
    end
    return res;
  endfunction

  function automatic in_t mk(int sx, int sy, int ex, int ey, int cx, int cy, int r);
    in_t q;
    q.start_x  = 16'(sx);
    q.start_y  = 16'(sy);
    q.end_x    = 16'(ex);
    q.end_y    = 16'(ey);
    q.centre_x = 16'(cx);
    q.centre_y = 16'(cy);
    q.radius   = 16'(r);
    return q;
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic int offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic in_t random_query();
    in_t q;
    int pick, r, cx, cy, d, a0, a1, lvl;
    int ext[5];
    ext = '{-32768, 32767, 0, -1, 1};
    pick = $urandom_range(0, 99);
    q.start_x  = 16'($urandom);
    q.start_y  = 16'($urandom);
    q.end_x    = 16'($urandom);
    q.end_y    = 16'($urandom);
    q.centre_x = 16'($urandom);
    q.centre_y = 16'($urandom);
    q.radius   = 16'($urandom);
    if (pick < 12) return q;
    if (pick < 18) begin
      q.radius = 16'(-int'($urandom_range(0, 32768)));
      return q;
    end
    if (pick < 24) begin
      q.start_x  = 16'(ext[$urandom_range(0, 4)]);
      q.start_y  = 16'(ext[$urandom_range(0, 4)]);
      q.end_x    = 16'(ext[$urandom_range(0, 4)]);
      q.end_y    = 16'(ext[$urandom_range(0, 4)]);
      q.centre_x = 16'(ext[$urandom_range(0, 4)]);
      q.centre_y = 16'(ext[$urandom_range(0, 4)]);
      q.radius   = 16'(ext[$urandom_range(0, 4)]);
      return q;
    end
    r = $urandom_range(1, 1 << $urandom_range(0, 15));
    if (r > 32767) r = 32767;
    cx = int'(q.centre_x);
    cy = int'(q.centre_y);
    q.radius = 16'(r);
    if (pick < 60) begin
      q.start_x = clip16(cx + offset(3 * r));
      q.start_y = clip16(cy + offset(3 * r));
      q.end_x   = clip16(cx + offset(3 * r));
      q.end_y   = clip16(cy + offset(3 * r));
    end else if (pick < 75) begin
      q.start_x = clip16(cx + offset(2 * r));
      q.start_y = clip16(cy + offset(2 * r));
      q.end_x   = q.start_x;
      q.end_y   = q.start_y;
    end else begin
      // chord grazing the circle: offset from centre is r-1, r or r+1
      d   = int'($urandom_range(0, 2)) - 1;
      lvl = ($urandom_range(0, 1) != 0) ? r + d : -(r + d);
      a0  = -int'($urandom_range(0, 4 * r));
      a1  = int'($urandom_range(0, 4 * r));
      if ($urandom_range(0, 1) != 0) begin
        d = a0;
        a0 = a1;
        a1 = d;
      end
      if ($urandom_range(0, 1) != 0) begin
        q.start_x = clip16(cx + a0);
        q.end_x   = clip16(cx + a1);
        q.start_y = clip16(cy + lvl);
        q.end_y   = q.start_y;
      end else begin
        q.start_y = clip16(cy + a0);
        q.end_y   = clip16(cy + a1);
        q.start_x = clip16(cx + lvl);
        q.end_x   = q.start_x;
      end
    end
    return q;
  endfunction

  function automatic int pick_gap();
    int p;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 5) burst_left = $urandom_range(20, 80);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 40) $display("%0t ns: %s", $time, msg);
  endtask

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_query(input in_t q, input bit typed, input out_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= q;
    drv_typed <= typed;
    drv_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      quiet++;
      if (out_valid && !out_stall) begin
        quiet = 0;
        if (verdict_q.size() == 0) begin
          note_error($sformatf("unexpected result %b", out_data));
        end else begin
          want = verdict_q.pop_front();
          if (out_data.intersects !== want.intersects)
            note_error($sformatf("intersects got %b want %b",
                                 out_data.intersects, want.intersects));
          if (out_data.bad_radius !== want.bad_radius)
            note_error($sformatf("bad_radius got %b want %b",
                                 out_data.bad_radius, want.bad_radius));
        end
      end
      if (in_valid && !in_stall) begin
        quiet = 0;
        verdict_q.push_back(drv_typed ? drv_want : segment_hits_disc(in_data));
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stall_gen
    int pct_pick[10];
    int pct, len;
    pct_pick = '{0, 0, 0, 12, 12, 12, 50, 50, 75, 100};
    forever begin
      pct = pct_pick[$urandom_range(0, 9)];
      len = (pct == 100) ? $urandom_range(5, 60) : $urandom_range(5, 80);
      repeat (len) begin
        @(negedge clk);
        out_stall <= (int'($urandom_range(0, 99)) < pct);
      end
    end
  end

  initial begin : stimulus
    row_t plan[];
    plan = '{
      '{mk(0, 0, 0, 0, 0, 0, 0), 1'b1, BAD_R},
      '{mk(5, 5, 9, 9, 5, 5, -1), 1'b1, BAD_R},
      '{mk(32767, -32768, -32768, 32767, 0, 0, -32768), 1'b1, BAD_R},
      '{mk(0, 0, 0, 0, 0, 0, 1), 1'b1, HIT},
      '{mk(0, 0, 0, 0, 0, 0, 32767), 1'b1, HIT},
      '{mk(3, 4, 3, 4, 0, 0, 5), 1'b1, HIT},
      '{mk(3, 4, 3, 4, 0, 0, 4), 1'b1, MISS},
      '{mk(1, 0, 1, 0, 0, 0, 1), 1'b1, HIT},
      '{mk(0, 0, 1000, 1000, 1, 1, 2), 1'b1, HIT},
      '{mk(-1000, 0, 0, 0, 0, 1, 1), 1'b1, HIT},
      '{mk(-100, 0, 100, 0, 0, 0, 10), 1'b1, HIT},
      '{mk(-100, 10, 100, 10, 0, 0, 10), 1'b1, HIT},
      '{mk(-100, 11, 100, 11, 0, 0, 10), 1'b1, MISS},
      '{mk(20, 0, 100, 0, 0, 0, 10), 1'b1, MISS},
      '{mk(-100, 0, -20, 0, 0, 0, 10), 1'b1, MISS},
      '{mk(0, 10, 10, 0, 0, 0, 7), 1'b1, MISS},
      '{mk(0, 10, 10, 0, 0, 0, 8), 1'b1, HIT},
      '{mk(-32768, -32768, 32767, 32767, 0, 0, 1), 1'b1, HIT},
      '{mk(32767, 32767, 32767, 32767, -32768, -32768, 32767), 1'b1, MISS},
      '{mk(-32768, 32767, 32767, -32768, 32767, 32767, 32767), 1'b0, MISS},
      '{mk(0, 0, -32768, 32767, -32768, -32768, 32767), 1'b0, MISS},
      '{mk(-32768, -32768, 32767, -32768, 32767, 32767, 32767), 1'b0, MISS},
      '{mk(21845, -21846, -21846, 21845, 21845, -21846, 21845), 1'b0, MISS},
      '{mk(-21846, 21845, 21845, -21846, -21846, 21845, 10922), 1'b0, MISS}
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (plan[i]) send_query(plan[i].query, plan[i].typed, plan[i].want);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // drain the pipe before resuming
        in_valid <= 1'b0;
        @(negedge clk);
        while (verdict_q.size() != 0) @(negedge clk);
      end
      send_query(random_query(), 1'b0, MISS);
    end
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
